@@ rtl/sdes_pkg.sv @@
// Constants, tables and permutation functions for the S-DES CBC cipher.
// No dependencies; used by sdes_core and sdes_cbc_cipher.
package sdes_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KEY = 2'd0;
  localparam logic [1:0] CFG_IV  = 2'd1;
  localparam logic [1:0] CFG_DIR = 2'd2;

  localparam logic [9:0] KEY_RESET = 10'd509;
  localparam logic [7:0] IV_RESET  = 8'hAA;

  // Permutation tables, 1-based positions counted from the most significant bit.
  localparam int unsigned P10_TAB [10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
  localparam int unsigned P8_TAB  [8]  = '{6, 3, 7, 4, 8, 5, 10, 9};
  localparam int unsigned IP_TAB  [8]  = '{2, 6, 3, 1, 4, 8, 5, 7};
  localparam int unsigned IPI_TAB [8]  = '{4, 1, 3, 5, 7, 2, 8, 6};
  localparam int unsigned EP_TAB  [8]  = '{4, 1, 2, 3, 2, 3, 4, 1};
  localparam int unsigned P4_TAB  [4]  = '{2, 4, 3, 1};

  localparam logic [1:0] S0_BOX [4][4] = '{
    '{2'd1, 2'd0, 2'd3, 2'd2}, '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1, 2'd3}, '{2'd3, 2'd1, 2'd3, 2'd2}};
  localparam logic [1:0] S1_BOX [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd1, 2'd0}, '{2'd2, 2'd1, 2'd0, 2'd3}};

  function automatic logic [9:0] perm_p10(logic [9:0] v);
    logic [9:0] r;
    for (int i = 0; i < 10; i++) r[9-i] = v[10-P10_TAB[i]];
    return r;
  endfunction

  function automatic logic [7:0] perm_p8(logic [9:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = v[10-P8_TAB[i]];
    return r;
  endfunction

  function automatic logic [7:0] perm_ip(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = v[8-IP_TAB[i]];
    return r;
  endfunction

  function automatic logic [7:0] perm_ipinv(logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = v[8-IPI_TAB[i]];
    return r;
  endfunction

  function automatic logic [7:0] expand_ep(logic [3:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = v[4-EP_TAB[i]];
    return r;
  endfunction

  function automatic logic [3:0] perm_p4(logic [3:0] v);
    logic [3:0] r;
    for (int i = 0; i < 4; i++) r[3-i] = v[4-P4_TAB[i]];
    return r;
  endfunction

  // Round function: expand, mix in the subkey, S-boxes, then P4.
  function automatic logic [3:0] round_f(logic [3:0] half, logic [7:0] sk);
    logic [7:0] e;
    logic [1:0] s0;
    logic [1:0] s1;
    e  = expand_ep(half) ^ sk;
    s0 = S0_BOX[{e[7], e[4]}][e[6:5]];
    s1 = S1_BOX[{e[3], e[0]}][e[2:1]];
    return perm_p4({s0, s1});
  endfunction

  // Full block: IP, round with ka, swap, round with kb, IP inverse.
  function automatic logic [7:0] sdes_block(logic [7:0] b, logic [7:0] ka,
                                            logic [7:0] kb);
    logic [7:0] x;
    logic [3:0] l;
    logic [3:0] r;
    x = perm_ip(b);
    l = x[3:0];
    r = x[7:4] ^ round_f(x[3:0], ka);
    l = l ^ round_f(r, kb);
    return perm_ipinv({l, r});
  endfunction

endpackage

@@ rtl/sdes_core.sv @@
// Combinational S-DES CBC datapath: key schedule, block cipher and chaining.
// Depends on sdes_pkg.
module sdes_core import sdes_pkg::*; (
  input  logic [7:0] data_i,
  input  logic [7:0] prev_i,
  input  logic [9:0] key_i,
  input  logic       decrypt_i,
  output logic [7:0] result_o,
  output logic [7:0] chain_o
);

  logic [9:0] key_p10;
  logic [4:0] hi1, lo1, hi2, lo2;
  logic [7:0] k1, k2;
  logic [7:0] enc_res, dec_res;

  always_comb begin
    key_p10 = perm_p10(key_i);
    hi1     = {key_p10[8:5], key_p10[9]};
    lo1     = {key_p10[3:0], key_p10[4]};
    hi2     = {hi1[2:0], hi1[4:3]};
    lo2     = {lo1[2:0], lo1[4:3]};
    k1      = perm_p8({hi1, lo1});
    k2      = perm_p8({hi2, lo2});
    enc_res = sdes_block(data_i ^ prev_i, k1, k2);
    dec_res = sdes_block(data_i, k2, k1) ^ prev_i;
    // The chain always carries the ciphertext byte.
    if (decrypt_i) begin
      result_o = dec_res;
      chain_o  = data_i;
    end else begin
      result_o = enc_res;
      chain_o  = enc_res;
    end
  end

endmodule

@@ rtl/sdes_cbc_cipher.sv @@
// Top level of the S-DES CBC cipher: input register, cipher datapath, result register.
// Depends on sdes_pkg and sdes_core.
//
// Usage: each request on the input channel carries one byte and a first flag; the
// flag restarts the chain from the initial vector. Each request yields exactly one
// result byte on the output channel, in order. Encryption chains the plaintext with
// the previous ciphertext before the cipher; decryption applies the subkeys in
// reverse and chains after the cipher.
// Configuration writes (key, initial vector, direction) go through their own port,
// which is always ready, and should only be issued while the block is empty.
// A request accepted into the input register is moved through the cipher into the
// result register once it is free and, if the receiver is ready, is taken from there.
// Throughput is one byte per cycle while the receiver is ready; the chain value
// settles in the same cycle as the result, which is what allows a byte to follow
// every cycle even in encryption mode.
// When the receiver stalls, the result register holds and the input register
// fills; input ready then drops until the result is taken, so nothing is lost.
// Reset returns the key to 509, the initial vector to 0xAA, the direction to
// encryption and clears the chain value and both valid flags.
module sdes_cbc_cipher import sdes_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_in_i,
  input  logic       first_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_out_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [9:0] cfg_data_i
);

  logic [9:0] key_q;
  logic [7:0] iv_q;
  logic       dir_q;
  logic [7:0] chain_q, chain_d;

  logic       s1_valid_q;
  logic [7:0] s1_data_q;
  logic       s1_first_q;

  logic       out_valid_q;
  logic [7:0] data_out_q, data_out_d;

  logic       out_free;
  logic       move;
  logic [7:0] prev;

  // The result register frees when empty or when its byte is taken this cycle.
  assign out_free    = !out_valid_q || out_ready_i;
  assign move        = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;
  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_out_q;
  assign cfg_ready_o = 1'b1;

  assign prev = s1_first_q ? iv_q : chain_q;

  sdes_core u_core (
    .data_i    (s1_data_q),
    .prev_i    (prev),
    .key_i     (key_q),
    .decrypt_i (dir_q),
    .result_o  (data_out_d),
    .chain_o   (chain_d)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KEY_RESET;
      iv_q  <= IV_RESET;
      dir_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_KEY: key_q <= cfg_data_i;
        CFG_IV:  iv_q  <= cfg_data_i[7:0];
        CFG_DIR: dir_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Valid flags and the chain value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (move) begin
        chain_q <= chain_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q  <= data_in_i;
      s1_first_q <= first_i;
    end
    if (move) begin
      data_out_q <= data_out_d;
    end
  end

  // In encryption the chain must follow the byte just produced.
  a_enc_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && !dir_q |=> chain_q == data_out_q)
    else $error("chain value differs from the last ciphertext");

  // In decryption the chain must follow the ciphertext just consumed.
  a_dec_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move && dir_q |=> chain_q == $past(s1_data_q))
    else $error("chain value differs from the last input ciphertext");

  // A byte waiting in the input register is not overwritten.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !move |=> s1_valid_q && $stable(s1_data_q))
    else $error("pending input byte lost");

  // An empty input register always takes a request.
  a_s1_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled while empty");

endmodule

@@ verif/tb_sdes_cbc_cipher.sv @@
// Self-checking testbench for the S-DES CBC cipher block sdes_cbc_cipher.
// Depends on sdes_pkg for the register indexes and reset values; drives random
// traffic and checks every output byte against an internal cipher model.
`timescale 1ns / 100ps

module tb_sdes_cbc_cipher import sdes_pkg::*; ();

  // The register list has three entries; index three selects nothing and a
  // write to it must leave every register untouched.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1500;
  localparam int MAX_REPORTS  = 10;

  // Permutation tables, packed four bits per entry with the first entry at the
  // top. Each entry names a source bit, counted from 1 at the most significant
  // end, exactly as the S-DES description lists them.
  localparam logic [39:0] KEY_P10 = {4'd3, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd1, 4'd9,
                                     4'd8, 4'd6};
  localparam logic [31:0] KEY_P8  = {4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10, 4'd9};
  localparam logic [31:0] BLK_IP  = {4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5, 4'd7};
  localparam logic [31:0] BLK_IPI = {4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8, 4'd6};
  localparam logic [31:0] HALF_EP = {4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1};
  localparam logic [15:0] SBOX_P4 = {4'd2, 4'd4, 4'd3, 4'd1};

  // S-boxes, row-major, two bits per entry with row 0 column 0 at the top.
  localparam logic [31:0] SUB0 = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                  2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
  localparam logic [31:0] SUB1 = {2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                  2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

  typedef enum logic {DIR_ENCRYPT = 1'b0, DIR_DECRYPT = 1'b1} dir_e;

  // Receiver behaviours, each held for a random stretch of cycles.
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_PULSED} rx_mode_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_in_i;
  logic       first_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] data_out_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [9:0] cfg_data_i;

  // Mirror of the block's registers and chaining state.
  logic [9:0] cur_key;
  logic [7:0] cur_iv;
  dir_e       cur_dir;
  logic [7:0] chain_byte;

  // Output bytes predicted for accepted requests, oldest first.
  logic [7:0] expected_bytes[$];
  logic [7:0] wanted_byte;
  int         fail_count;
  int         burst_left;
  rx_mode_e   rx_mode;
  int         rx_hold;

  sdes_cbc_cipher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_in_i   (data_in_i),
    .first_i     (first_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_out_o  (data_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Behavioural cipher model
  // ---------------------------------------------------------------------------

  // Builds an n-bit value whose bit i (from the top) is source bit tab[i] of a
  // src_w-bit source, counted from 1 at the most significant end.
  function automatic logic [9:0] pick_bits(input logic [9:0] src, input int src_w,
                                           input logic [39:0] tab, input int n);
    logic [9:0] res;
    int         pos;
    res = '0;
    for (int i = 0; i < n; i++) begin
      pos = int'(tab[4*(n-1-i) +: 4]);
      res[n-1-i] = src[src_w-pos];
    end
    return res;
  endfunction

  function automatic logic [4:0] rotl5(input logic [4:0] v, input int s);
    logic [9:0] both;
    both = {v, v} << s;
    return both[9:5];
  endfunction

  // Row comes from the outer bits of the nibble, column from the inner pair.
  function automatic logic [1:0] sub_lookup(input logic [31:0] box, input logic [3:0] v);
    int cell_idx;
    cell_idx = {v[3], v[0]} * 4 + v[2:1];
    return box[2*(15-cell_idx) +: 2];
  endfunction

  function automatic logic [3:0] feistel_f(input logic [3:0] half, input logic [7:0] sk);
    logic [7:0] mixed;
    logic [3:0] sbox_out;
    mixed    = 8'(pick_bits({6'd0, half}, 4, 40'(HALF_EP), 8)) ^ sk;
    sbox_out = {sub_lookup(SUB0, mixed[7:4]), sub_lookup(SUB1, mixed[3:0])};
    return 4'(pick_bits({6'd0, sbox_out}, 4, 40'(SBOX_P4), 4));
  endfunction

  // Returns {K1, K2}.
  function automatic logic [15:0] derive_subkeys(input logic [9:0] key);
    logic [9:0] p;
    logic [4:0] hi;
    logic [4:0] lo;
    logic [7:0] k1;
    logic [7:0] k2;
    p  = pick_bits(key, 10, KEY_P10, 10);
    hi = rotl5(p[9:5], 1);
    lo = rotl5(p[4:0], 1);
    k1 = 8'(pick_bits({hi, lo}, 10, 40'(KEY_P8), 8));
    hi = rotl5(hi, 2);
    lo = rotl5(lo, 2);
    k2 = 8'(pick_bits({hi, lo}, 10, 40'(KEY_P8), 8));
    return {k1, k2};
  endfunction

  // One block through the network: IP, round with ka, swap, round with kb, IP^-1.
  function automatic logic [7:0] sdes_byte(input logic [7:0] b, input logic [7:0] ka,
                                           input logic [7:0] kb);
    logic [7:0] x;
    logic [3:0] l;
    logic [3:0] r;
    logic [3:0] t;
    x = 8'(pick_bits({2'd0, b}, 8, 40'(BLK_IP), 8));
    l = x[7:4] ^ feistel_f(x[3:0], ka);
    r = x[3:0];
    t = l;
    l = r;
    r = t;
    l = l ^ feistel_f(r, kb);
    return 8'(pick_bits({2'd0, l, r}, 8, 40'(BLK_IPI), 8));
  endfunction

  // Predicts the output byte for one accepted request and advances the chain.
  function automatic logic [7:0] cbc_next_byte(input logic [7:0] din, input logic restart);
    logic [7:0]  prev;
    logic [15:0] keys;
    logic [7:0]  res;
    prev = restart ? cur_iv : chain_byte;
    keys = derive_subkeys(cur_key);
    if (cur_dir == DIR_ENCRYPT) begin
      res        = sdes_byte(din ^ prev, keys[15:8], keys[7:0]);
      chain_byte = res;
    end else begin
      res        = sdes_byte(din, keys[7:0], keys[15:8]) ^ prev;
      chain_byte = din;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, receiver and result checking
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver switches between behaviours at random, so that
  // stalls land on every phase of the pipeline, with free-running stretches too.
  always @(posedge clk_i) begin
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_hold <= $urandom_range(16, 160);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RX_FREE:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_SLOW:   out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= ((rx_hold % 7) < 3);
    endcase
  end

  // Every result taken from the block is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result %02h arrived with no request outstanding", $realtime,
                   data_out_o);
      end else begin
        wanted_byte = expected_bytes.pop_front();
        if (data_out_o !== wanted_byte) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: data_out mismatch, expected %02h, got %02h", $realtime,
                     wanted_byte, data_out_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------

  // Sends one request. Valid is left high after acceptance so that back-to-back
  // requests never see valid lowered and raised within the same time step; it
  // only drops at the start of a gap or when the sender waits for the block to
  // empty.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    data_in_i  <= b;
    first_i    <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    expected_bytes.push_back(cbc_next_byte(b, restart));
  endtask

  // Stops sending and waits until every predicted result has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Writes one register; valid stays high across a run of writes and is
  // lowered with the last one.
  task automatic write_reg(input logic [1:0] idx, input logic [9:0] value, input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid_i <= 1'b0;
    case (idx)
      CFG_KEY: cur_key = value;
      CFG_IV:  cur_iv  = value[7:0];
      CFG_DIR: cur_dir = dir_e'(value[0]);
      default: ;
    endcase
  endtask

  // Loads all three registers; spare data bits above each width are random.
  task automatic load_regs(input logic [9:0] key, input logic [7:0] iv, input dir_e dir);
    write_reg(CFG_KEY, key, 1'b0);
    write_reg(CFG_IV, {2'($urandom_range(0, 3)), iv}, 1'b0);
    write_reg(CFG_DIR, {9'($urandom_range(0, 511)), dir}, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset: the chain starts at zero until a first byte arrives,
  // and the reset key and initial vector are in force.
  task automatic test_reset_state();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h00, 1'b0);
    wait_drained();
  endtask

  // A write to the unused index must change nothing, and data bits above a
  // register's width must be dropped (the direction below stays at encrypt).
  task automatic test_register_masking();
    write_reg(CFG_UNUSED, 10'h3FF, 1'b0);
    write_reg(CFG_IV, 10'h355, 1'b0);
    write_reg(CFG_DIR, 10'h3FE, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    wait_drained();
  endtask

  // All-zero and all-one keys in both directions, with the extreme vectors.
  task automatic test_key_extremes();
    for (int k = 0; k < 2; k++) begin
      for (int d = 0; d < 2; d++) begin
        load_regs(k ? 10'h3FF : 10'h000, k ? 8'hFF : 8'h00, dir_e'(d));
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        wait_drained();
      end
    end
  endtask

  // Turning to decryption mid-message keeps the chain value as it stands.
  task automatic test_direction_switch();
    load_regs(10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)), DIR_ENCRYPT);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_drained();
    write_reg(CFG_DIR, {9'd0, DIR_DECRYPT}, 1'b1);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b0);
    wait_drained();
  endtask

  // Random messages under a sequence of register settings. Most messages open
  // with a first byte and chain the rest; about one in eight carries random
  // first flags instead. Now and then the sender waits for the block to empty
  // in the middle of a phase.
  task automatic test_random_messages();
    int         sent;
    int         phase;
    int         phase_left;
    int         msg_len;
    bit         ragged;
    logic [9:0] key;
    logic [7:0] iv;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_drained();
      case (phase % 4)
        0:       key = 10'h000;
        1:       key = 10'h3FF;
        default: key = 10'($urandom_range(0, 1023));
      endcase
      case (phase % 3)
        0:       iv = 8'h00;
        1:       iv = 8'hFF;
        default: iv = 8'($urandom_range(0, 255));
      endcase
      load_regs(key, iv, dir_e'(phase % 2));
      phase_left = $urandom_range(80, 200);
      while (phase_left > 0) begin
        msg_len = $urandom_range(1, 12);
        ragged  = ($urandom_range(0, 7) == 0);
        for (int j = 0; j < msg_len; j++)
          send_byte(8'($urandom_range(0, 255)),
                    ragged ? 1'($urandom_range(0, 1)) : (j == 0));
        phase_left -= msg_len;
        sent       += msg_len;
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
      phase++;
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    data_in_i   <= '0;
    first_i     <= 1'b0;
    out_ready_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_KEY;
    cfg_data_i  <= '0;
    rx_mode     = RX_FREE;
    rx_hold     = 0;
    burst_left  = 0;
    fail_count  = 0;
    cur_key     = KEY_RESET;
    cur_iv      = IV_RESET;
    cur_dir     = DIR_ENCRYPT;
    chain_byte  = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_register_masking();
    test_key_extremes();
    test_direction_switch();
    test_random_messages();

    // Allow the two-stage pipeline to show anything left over.
    repeat (6) @(posedge clk_i);
    fail_count += expected_bytes.size();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sdes_cbc_cipher.f @@
rtl/sdes_pkg.sv
rtl/sdes_core.sv
rtl/sdes_cbc_cipher.sv
verif/tb_sdes_cbc_cipher.sv
